/* design/rmq_pkg.sv */
// Shared constants, types and saturation helper for the rotation matrix to
// quaternion pipeline. No dependencies.
package rmq_pkg;

	localparam int DW  = 16;                   // element and component width
	localparam int FB  = 14;                   // fraction bits
	localparam int AW  = DW + 3;               // root argument, signed
	localparam int MW  = DW + 1;               // pair sum or difference magnitude
	localparam int NW  = ((DW + FB + 2) / 2) * 2; // root radicand, even width
	localparam int RW  = NW / 2;               // root width
	localparam int QNW = DW + FB + 2;          // dividend and quotient width

	typedef enum logic [1:0] {
		PATH_W = 2'd0,
		PATH_X = 2'd1,
		PATH_Y = 2'd2,
		PATH_Z = 2'd3
	} path_t;

	typedef struct packed {
		path_t      path;
		logic       fault;
		logic [2:0] neg;
	} meta_t;

	typedef logic [2:0][MW-1:0]  mag3_t;
	typedef logic [2:0][QNW-1:0] quo3_t;

	// clamp a magnitude with sign into the signed DW range
	function automatic logic [DW-1:0] sat_mag(input logic [QNW-1:0] m, input logic neg);
		logic [QNW-1:0] lim_p;
		logic [QNW-1:0] lim_n;
		logic [QNW-1:0] neg_m;
		logic [DW-1:0]  res;
		lim_p = {{(QNW-DW+1){1'b0}}, {(DW-1){1'b1}}};
		lim_n = lim_p + 1'b1;
		neg_m = ~m + 1'b1;
		if (neg) begin
			if (m > lim_n)
				res = lim_n[DW-1:0];
			else
				res = neg_m[DW-1:0];
		end else begin
			if (m > lim_p)
				res = lim_p[DW-1:0];
			else
				res = m[DW-1:0];
		end
		return res;
	endfunction

endpackage

/* design/rotation_matrix_to_quaternion_top.sv */
// Pipeline: one input stage, one stage per root bit, one stage per quotient bit,
// one output register.
// Throughput: one beat per cycle; the whole pipeline holds while a finished
// beat waits at the output. Reset clears all valid bits; payload is not reset.
// Depends on rmq_pkg, rmq_front, rmq_sqrt, rmq_div, rmq_out.
module rotation_matrix_to_quaternion_top import rmq_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	// ex_x, ex_y, ex_z, ey_x, ey_y, ey_z, ez_x, ez_y, ez_z
	input  logic [9*DW-1:0] s_tdata,
	output logic            m_tvalid,
	input  logic            m_tready,
	// quat_w, quat_x, quat_y, quat_z
	output logic [4*DW-1:0] m_tdata,
	// path_taken[1:0], fault
	output logic [2:0]      m_tuser
);

	logic          ce;
	logic          f_valid, q_valid, d_valid;
	logic [NW-1:0] f_n;
	meta_t         f_meta, q_meta, d_meta;
	mag3_t         f_mag, q_mag;
	logic [RW-1:0] q_root, d_root;
	quo3_t         d_quo;

	assign s_tready = ce;

	rmq_front u_front (
		.clk(clk), .arst_n(arst_n), .ce(ce),
		.in_valid(s_tvalid && s_tready), .in_data(s_tdata),
		.out_valid(f_valid), .n_out(f_n), .meta_out(f_meta), .mag_out(f_mag)
	);

	rmq_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .ce(ce),
		.in_valid(f_valid), .n_in(f_n), .meta_in(f_meta), .mag_in(f_mag),
		.out_valid(q_valid), .root_out(q_root), .meta_out(q_meta), .mag_out(q_mag)
	);

	rmq_div u_div (
		.clk(clk), .arst_n(arst_n), .ce(ce),
		.in_valid(q_valid), .root_in(q_root), .meta_in(q_meta), .mag_in(q_mag),
		.out_valid(d_valid), .root_out(d_root), .meta_out(d_meta), .quo_out(d_quo)
	);

	rmq_out u_out (
		.clk(clk), .arst_n(arst_n),
		.in_valid(d_valid), .root_in(d_root), .meta_in(d_meta), .quo_in(d_quo),
		.out_ready(m_tready), .ce(ce),
		.out_valid(m_tvalid), .out_data(m_tdata), .out_user(m_tuser)
	);

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tdata == '0)
		else $error("faulted beat carries nonzero components");

	a_trace_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] == PATH_W |-> !m_tuser[2])
		else $error("trace branch flagged a fault");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without an output stall");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("waiting output beat changed");

endmodule

/* design/rmq_front.sv */
// Input stage: trace, branch choice, root argument and off-diagonal pairs.
// Depends on rmq_pkg.
module rmq_front import rmq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             ce,
	input  logic             in_valid,
	input  logic [9*DW-1:0]  in_data,
	output logic             out_valid,
	output logic [NW-1:0]    n_out,
	output meta_t            meta_out,
	output mag3_t            mag_out
);

	localparam logic signed [AW-1:0] ONE = AW'(1 << FB);

	logic signed [DW-1:0] e [9];
	logic signed [AW-1:0] tr, a;
	logic signed [DW-1:0] mx;
	logic signed [MW-1:0] d [3];
	path_t                path;
	logic                 fault;
	meta_t                meta;
	mag3_t                mag;
	logic [NW-1:0]        n;

	always_comb begin
		for (int i = 0; i < 9; i++)
			e[i] = signed'(in_data[i*DW +: DW]);
		tr = AW'(e[0]) + AW'(e[4]) + AW'(e[8]);
		mx = e[0];
		if (!tr[AW-1]) begin
			path = PATH_W;
		end else begin
			path = PATH_X;
			if (e[4] > mx) begin
				path = PATH_Y;
				mx   = e[4];
			end
			if (e[8] > mx)
				path = PATH_Z;
		end
		case (path)
			PATH_W: begin
				a    = tr + ONE;
				d[0] = MW'(e[5]) - MW'(e[7]);
				d[1] = MW'(e[6]) - MW'(e[2]);
				d[2] = MW'(e[1]) - MW'(e[3]);
			end
			PATH_X: begin
				a    = AW'(e[0]) - AW'(e[4]) - AW'(e[8]) + ONE;
				d[0] = MW'(e[5]) - MW'(e[7]);
				d[1] = MW'(e[3]) + MW'(e[1]);
				d[2] = MW'(e[2]) + MW'(e[6]);
			end
			PATH_Y: begin
				a    = AW'(e[4]) - AW'(e[8]) - AW'(e[0]) + ONE;
				d[0] = MW'(e[6]) - MW'(e[2]);
				d[1] = MW'(e[3]) + MW'(e[1]);
				d[2] = MW'(e[7]) + MW'(e[5]);
			end
			default: begin
				a    = AW'(e[8]) - AW'(e[0]) - AW'(e[4]) + ONE;
				d[0] = MW'(e[1]) - MW'(e[3]);
				d[1] = MW'(e[2]) + MW'(e[6]);
				d[2] = MW'(e[7]) + MW'(e[5]);
			end
		endcase
		fault = a[AW-1] || (a == '0);
		for (int j = 0; j < 3; j++)
			mag[j] = d[j][MW-1] ? MW'(-d[j]) : MW'(d[j]);
		meta.path  = path;
		meta.fault = fault;
		meta.neg   = {d[2][MW-1], d[1][MW-1], d[0][MW-1]};
		n = fault ? '0 : (NW'(a[DW:0]) << FB);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (ce)
			out_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			n_out    <= n;
			meta_out <= meta;
			mag_out  <= mag;
		end
	end

endmodule

/* design/rmq_sqrt.sv */
// Pipelined integer square root, one root bit per stage, side data carried.
// Depends on rmq_pkg.
module rmq_sqrt import rmq_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          ce,
	input  logic          in_valid,
	input  logic [NW-1:0] n_in,
	input  meta_t         meta_in,
	input  mag3_t         mag_in,
	output logic          out_valid,
	output logic [RW-1:0] root_out,
	output meta_t         meta_out,
	output mag3_t         mag_out
);

	logic          v_s    [RW+1];
	logic [NW-1:0] n_s    [RW+1];
	logic [RW+1:0] rem_s  [RW+1];
	logic [RW-1:0] root_s [RW+1];
	meta_t         meta_s [RW+1];
	mag3_t         mag_s  [RW+1];

	assign v_s[0]    = in_valid;
	assign n_s[0]    = n_in;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign meta_s[0] = meta_in;
	assign mag_s[0]  = mag_in;

	for (genvar k = 0; k < RW; k++) begin : g_stage
		localparam int I = RW - 1 - k;
		logic [RW+2:0] sh, trial, diff;
		logic          ge;

		assign sh    = {rem_s[k][RW:0], n_s[k][2*I+1 -: 2]};
		assign trial = {1'b0, root_s[k], 2'b01};
		assign diff  = sh - trial;
		assign ge    = sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k+1] <= 1'b0;
			else if (ce)
				v_s[k+1] <= v_s[k];
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				root_s[k+1] <= {root_s[k][RW-2:0], ge};
				meta_s[k+1] <= meta_s[k];
				mag_s[k+1]  <= mag_s[k];
			end
		end

		if (k < RW - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (ce) begin
					rem_s[k+1] <= ge ? diff[RW+1:0] : sh[RW+1:0];
					n_s[k+1]   <= n_s[k];
				end
			end
		end
	end

	assign out_valid = v_s[RW];
	assign root_out  = root_s[RW];
	assign meta_out  = meta_s[RW];
	assign mag_out   = mag_s[RW];

endmodule

/* design/rmq_div.sv */
// Three-lane pipelined restoring divider sharing the divisor 2*root,
// one quotient bit per stage. Depends on rmq_pkg.
module rmq_div import rmq_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          ce,
	input  logic          in_valid,
	input  logic [RW-1:0] root_in,
	input  meta_t         meta_in,
	input  mag3_t         mag_in,
	output logic          out_valid,
	output logic [RW-1:0] root_out,
	output meta_t         meta_out,
	output quo3_t         quo_out
);

	logic                   v_s    [QNW+1];
	logic [RW-1:0]          root_s [QNW+1];
	meta_t                  meta_s [QNW+1];
	quo3_t                  num_s  [QNW+1];
	logic [2:0][RW:0]       rem_s  [QNW+1];
	quo3_t                  q_s    [QNW+1];

	assign v_s[0]    = in_valid;
	assign root_s[0] = root_in;
	assign meta_s[0] = meta_in;
	assign rem_s[0]  = '0;
	assign q_s[0]    = '0;

	// dividend = |d| * 2^FB + r, rounds the quotient to nearest
	always_comb begin
		for (int j = 0; j < 3; j++)
			num_s[0][j] = (QNW'(mag_in[j]) << FB) + QNW'(root_in);
	end

	for (genvar k = 0; k < QNW; k++) begin : g_stage
		localparam int B = QNW - 1 - k;
		logic [RW:0]      dv;
		logic [2:0][RW:0] rem_n;
		quo3_t            q_n;

		assign dv = {root_s[k], 1'b0};

		always_comb begin
			logic [RW+1:0] sh;
			logic [RW+1:0] diff;
			logic          ge;
			for (int j = 0; j < 3; j++) begin
				sh       = {rem_s[k][j], num_s[k][j][B]};
				diff     = sh - {1'b0, dv};
				ge       = sh >= {1'b0, dv};
				rem_n[j] = ge ? diff[RW:0] : sh[RW:0];
				q_n[j]   = {q_s[k][j][QNW-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k+1] <= 1'b0;
			else if (ce)
				v_s[k+1] <= v_s[k];
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				root_s[k+1] <= root_s[k];
				meta_s[k+1] <= meta_s[k];
				q_s[k+1]    <= q_n;
			end
		end

		if (k < QNW - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (ce) begin
					rem_s[k+1] <= rem_n;
					num_s[k+1] <= num_s[k];
				end
			end
		end
	end

	assign out_valid = v_s[QNW];
	assign root_out  = root_s[QNW];
	assign meta_out  = meta_s[QNW];
	assign quo_out   = q_s[QNW];

endmodule

/* design/rmq_out.sv */
// Output stage: own component, sign and saturation, placement, output register
// and the pipeline advance enable. Depends on rmq_pkg.
module rmq_out import rmq_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [RW-1:0] root_in,
	input  meta_t         meta_in,
	input  quo3_t         quo_in,
	input  logic          out_ready,
	output logic          ce,
	output logic          out_valid,
	output logic [4*DW-1:0] out_data,
	output logic [2:0]    out_user
);

	logic [RW:0]          own_sum;
	logic [DW-1:0]        own;
	logic [3:0][DW-1:0]   comp;

	assign ce = !out_valid || out_ready;

	always_comb begin
		int k;
		k       = 0;
		own_sum = {1'b0, root_in} + 1'b1;
		own     = sat_mag(QNW'(own_sum[RW:1]), 1'b0);
		for (int i = 0; i < 4; i++) begin
			if (i == int'(meta_in.path)) begin
				comp[i] = own;
			end else begin
				comp[i] = sat_mag(quo_in[k], meta_in.neg[k]);
				k++;
			end
		end
		if (meta_in.fault)
			comp = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (ce)
			out_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			out_data <= comp;
			out_user <= {meta_in.fault, meta_in.path};
		end
	end

endmodule

/* sim/testbench.sv */
// Self-checking testbench for rotation_matrix_to_quaternion_top: streams
// matrices in, predicts each quaternion and compares it beat by beat.
// Depends on rmq_pkg and the RTL under design/.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import rmq_pkg::*;

	typedef struct packed {
		logic [DW-1:0] w;
		logic [DW-1:0] x;
		logic [DW-1:0] y;
		logic [DW-1:0] z;
		path_t         path;
		logic          fault;
	} quat_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            s_tvalid = 1'b0;
	logic            s_tready;
	logic [9*DW-1:0] s_tdata = '0;
	logic            m_tvalid;
	logic            m_tready = 1'b0;
	logic [4*DW-1:0] m_tdata;
	logic [2:0]      m_tuser;

	quat_t quat_queue[$];
	int    mismatches = 0;
	int    idle_cycles = 0;
	int    sink_stall = 0;
	bit    src_idle_on = 1'b1;
	bit    sink_idle_on = 1'b1;

	localparam int LIMIT = 4000;

	rotation_matrix_to_quaternion_top uut (.*);

	always #4 clk = ~clk;

	function automatic longint sat_dw(input longint v);
		longint hi;
		hi = (longint'(1) <<< (DW-1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	function automatic longint int_sqrt(input longint n);
		longint r;
		longint b;
		r = 0;
		b = longint'(1) <<< 62;
		while (b > n) b = b >>> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >>> 1) + b;
			end else
				r = r >>> 1;
			b = b >>> 2;
		end
		return r;
	endfunction

	function automatic longint scale_pair(input longint d, input longint r);
		longint m;
		longint q;
		m = (d < 0) ? -d : d;
		q = ((m <<< FB) + r) / (2 * r);
		return sat_dw((d < 0) ? -q : q);
	endfunction

	function automatic quat_t predict_quat(input logic [9*DW-1:0] mat);
		longint e[9];
		longint q[4];
		longint d[3];
		longint a, tr, mx, r;
		int     p, k;
		quat_t  res;
		for (int i = 0; i < 9; i++) e[i] = longint'($signed(mat[i*DW +: DW]));
		for (int i = 0; i < 4; i++) q[i] = 0;
		tr = e[0] + e[4] + e[8];
		if (tr >= 0) begin
			p = PATH_W;
			a = tr + (1 <<< FB);
			d[0] = e[5] - e[7]; d[1] = e[6] - e[2]; d[2] = e[1] - e[3];
		end else begin
			p = PATH_X; mx = e[0];
			if (e[4] > mx) begin p = PATH_Y; mx = e[4]; end
			if (e[8] > mx) p = PATH_Z;
			case (p)
				PATH_X: begin
					a = e[0] - e[4] - e[8] + (1 <<< FB);
					d[0] = e[5] - e[7]; d[1] = e[3] + e[1]; d[2] = e[2] + e[6];
				end
				PATH_Y: begin
					a = e[4] - e[8] - e[0] + (1 <<< FB);
					d[0] = e[6] - e[2]; d[1] = e[3] + e[1]; d[2] = e[7] + e[5];
				end
				default: begin
					a = e[8] - e[0] - e[4] + (1 <<< FB);
					d[0] = e[1] - e[3]; d[1] = e[2] + e[6]; d[2] = e[7] + e[5];
				end
			endcase
		end
		res.fault = (a <= 0);
		if (a > 0) begin
			r = int_sqrt(a <<< FB);
			q[p] = sat_dw((r + 1) >>> 1);
			k = 0;
			for (int i = 0; i < 4; i++)
				if (i != p) begin
					q[i] = scale_pair(d[k], r);
					k++;
				end
		end
		res.w = q[0][DW-1:0]; res.x = q[1][DW-1:0];
		res.y = q[2][DW-1:0]; res.z = q[3][DW-1:0];
		res.path = path_t'(p[1:0]);
		return res;
	endfunction

	// send one matrix, sometimes with a random gap ahead of it
	task automatic send_matrix(input logic [9*DW-1:0] mat);
		int gap;
		gap = (src_idle_on && $urandom_range(3) == 0) ? $urandom_range(14, 1) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= mat;
		quat_queue.push_back(predict_quat(mat));
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic end_stream();
		s_tvalid <= 1'b0;
	endtask

	function automatic logic [9*DW-1:0] pack_mat(input longint m[9]);
		logic [9*DW-1:0] v;
		for (int i = 0; i < 9; i++) v[i*DW +: DW] = m[i][DW-1:0];
		return v;
	endfunction

	function automatic logic [DW-1:0] rand_elem();
		case ($urandom_range(5))
			0: return {1'b0, {(DW-1){1'b1}}};
			1: return {1'b1, {(DW-1){1'b0}}};
			2: return DW'(1 << FB);
			3: return -DW'(1 << FB);
			default: return DW'($urandom());
		endcase
	endfunction

	// rotation from a random quaternion, normalized before use, with optional jitter
	function automatic logic [9*DW-1:0] rand_rotation(input int jitter);
		real qw, qx, qy, qz, n;
		real m[9];
		longint v[9];
		qw = $urandom_range(2000) - 1000.0; qx = $urandom_range(2000) - 1000.0;
		qy = $urandom_range(2000) - 1000.0; qz = $urandom_range(2000) - 1000.0;
		n = $sqrt(qw*qw + qx*qx + qy*qy + qz*qz);
		if (n == 0.0) begin qw = 1.0; n = 1.0; end
		qw /= n; qx /= n; qy /= n; qz /= n;
		m[0] = 1 - 2*(qy*qy + qz*qz); m[1] = 2*(qx*qy + qw*qz); m[2] = 2*(qx*qz - qw*qy);
		m[3] = 2*(qx*qy - qw*qz); m[4] = 1 - 2*(qx*qx + qz*qz); m[5] = 2*(qy*qz + qw*qx);
		m[6] = 2*(qx*qz + qw*qy); m[7] = 2*(qy*qz - qw*qx); m[8] = 1 - 2*(qx*qx + qy*qy);
		for (int i = 0; i < 9; i++) begin
			v[i] = longint'($rtoi(m[i] * (1 << FB)));
			if (jitter > 0) v[i] += $signed($urandom_range(2*jitter)) - jitter;
		end
		return pack_mat(v);
	endfunction

	task automatic test_directed();
		longint m[9];
		longint one;
		one = 1 <<< FB;
		// identity and half turns about each axis
		m = '{one, 0, 0, 0, one, 0, 0, 0, one};     send_matrix(pack_mat(m));
		m = '{one, 0, 0, 0, -one, 0, 0, 0, -one};   send_matrix(pack_mat(m));
		m = '{-one, 0, 0, 0, one, 0, 0, 0, -one};   send_matrix(pack_mat(m));
		m = '{-one, 0, 0, 0, -one, 0, 0, 0, one};   send_matrix(pack_mat(m));
		// diagonal ties: earlier axis wins
		m = '{-one, 0, 0, 0, -one, 0, 0, 0, -one};  send_matrix(pack_mat(m));
		m = '{0, 0, 0, 0, 0, 0, 0, 0, -1};          send_matrix(pack_mat(m));
		m = '{-100, 5, 7, 9, -100, 3, 2, 1, -200};  send_matrix(pack_mat(m));
		m = '{-200, 5, 7, 9, -100, 3, 2, 1, -100};  send_matrix(pack_mat(m));
		// trace exactly zero
		m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};           send_matrix(pack_mat(m));
		// negative trace in the X, Y and Z branches
		m = '{-32768, 0, 0, 0, 32767, 0, 0, 0, -32768}; send_matrix(pack_mat(m));
		m = '{-20000, 0, 0, 0, -20000, 0, 0, 0, -20000}; send_matrix(pack_mat(m));
		m = '{-32768, 0, 0, 0, -32768, 0, 0, 0, 32767}; send_matrix(pack_mat(m));
		m = '{-one, 0, 0, 0, -one, 0, 0, 0, -one+1}; send_matrix(pack_mat(m));
		// extreme element values for the pair terms and the own component
		m = '{-32768, 32767, 32767, 32767, -32768, -32768, 32767, -32768, -32767};
		send_matrix(pack_mat(m));
		m = '{32767, 32767, -32768, -32768, 32767, -32768, 32767, 32767, 32767};
		send_matrix(pack_mat(m));
		m = '{0, -32768, 32767, 32767, 0, -32768, -32768, 32767, 0};
		send_matrix(pack_mat(m));
		m = '{-1, -32768, -32768, -32768, -32767, -32768, -32768, -32768, -32768};
		send_matrix(pack_mat(m));
		m = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
		send_matrix(pack_mat(m));
		m = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
		send_matrix(pack_mat(m));
		m = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};  send_matrix(pack_mat(m));
	endtask

	task automatic test_rotations(input int n);
		for (int i = 0; i < n; i++)
			send_matrix(rand_rotation(($urandom_range(3) == 0) ? 300 : 0));
	endtask

	task automatic test_noise(input int n);
		logic [9*DW-1:0] v;
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j < 9; j++) v[j*DW +: DW] = rand_elem();
			send_matrix(v);
		end
	endtask

	// output sink: random stalls, compare against the oldest prediction
	always @(posedge clk) begin
		quat_t got;
		quat_t exp_q;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = {m_tdata[0*DW +: DW], m_tdata[1*DW +: DW], m_tdata[2*DW +: DW],
					m_tdata[3*DW +: DW], path_t'(m_tuser[1:0]), m_tuser[2]};
				if (quat_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected beat: %h", got);
				end else begin
					exp_q = quat_queue.pop_front();
					if (got !== exp_q) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: exp w %h x %h y %h z %h path %0d fault %b",
								" | got w %h x %h y %h z %h path %0d fault %b"},
								exp_q.w, exp_q.x, exp_q.y, exp_q.z, exp_q.path, exp_q.fault,
								got.w, got.x, got.y, got.z, got.path, got.fault);
					end
				end
			end
			// stall bursts of random length
			if (sink_stall > 0) begin
				m_tready   <= 1'b0;
				sink_stall <= sink_stall - 1;
			end else if (sink_idle_on && $urandom_range(7) == 0) begin
				m_tready   <= 1'b0;
				sink_stall <= $urandom_range(13, 0);
			end else
				m_tready <= 1'b1;
		end
	end

	// watchdog: cycles with no beat accepted on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= LIMIT) begin
			$display("rotation_matrix_to_quaternion_top regression: fail");
			$finish;
		end
	end

	initial begin
		int wait_cycles;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_rotations(1000);
		test_noise(500);
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		test_rotations(150);
		test_noise(80);
		end_stream();
		wait_cycles = 0;
		while (quat_queue.size() != 0 && wait_cycles < 20 * LIMIT) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (60) @(posedge clk);
		if (mismatches == 0 && quat_queue.size() == 0)
			$display("rotation_matrix_to_quaternion_top regression: pass");
		else
			$display("rotation_matrix_to_quaternion_top regression: fail");
		$finish;
	end

endmodule
